// File: hdl/dd_pkg.sv
package dd_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = 14;

  typedef enum logic [3:0] {
    OP_TICK    = 4'd0,
    OP_FWD     = 4'd1,
    OP_BACK    = 4'd2,
    OP_LEFT    = 4'd3,
    OP_RIGHT   = 4'd4,
    OP_IDLE    = 4'd5,
    OP_BRK_ON  = 4'd6,
    OP_BRK_OFF = 4'd7,
    OP_ACC_ON  = 4'd8,
    OP_ACC_OFF = 4'd9
  } dd_op_e;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_CURRENT = 3'd1,
    KIND_RPM     = 3'd2,
    KIND_BRAKE   = 3'd3,
    KIND_KILL    = 3'd4
  } dd_kind_e;

  typedef enum logic [2:0] {
    REG_MAX_RPM     = 3'd0,
    REG_START_SPEED = 3'd1,
    REG_TURN_RATE   = 3'd2,
    REG_ACCEL_STEP  = 3'd3,
    REG_REV_EN      = 3'd4,
    REG_REV_CUR     = 3'd5
  } dd_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_DIV  = 3'd1,
    ST_EXEC = 3'd2,
    ST_MUL  = 3'd3,
    ST_EMIT = 3'd4
  } dd_state_e;

  // max_rpm is never zero here; speed values are capped at 1.0
  typedef struct packed {
    logic [16:0] max_rpm;
    logic [14:0] start_speed;
    logic [14:0] turn_rate;
    logic [14:0] accel_step;
    logic        rev_en;
    logic [16:0] rev_cur;
  } dd_cfg_t;

  typedef struct packed {
    dd_op_e      op;
    logic        neg;
    logic        nz;
    logic [17:0] mag;
    logic        fast;
    logic        rev_ok;
  } dd_item_t;

endpackage

// File: hdl/differential_drive_motion_control.sv
// Differential-drive motion controller. Each request carries one command
// (tick, go forward/back, turn left/right, idle, brake on/off, accelerate
// on/off) and the latest left and right motor rpm; it yields zero to six motor
// commands (set current, set rpm, brake, kill), each with the throttles after
// the request and a notify flag, the last one marked by last_o. A front stage
// takes a request in, averages the rpm and classifies it against max_rpm;
// reserved operation codes are dropped there with no result. A short queue
// decouples it from the back sequencer, which runs one request at a time:
// it fetches the request, runs a restoring divide when the measured speed
// exceeds 0.1 but is below 1.0 and must be converted to Q1.14 (1.0 or more
// is taken as 1.0), updates state, runs the shared multiplier for the left
// then right set-rpm values, then yields one result per cycle while the
// output is not stalled. Write configuration only while idle.
module differential_drive_motion_control #(
  parameter int QueueDepth = dd_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [16:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         operation_i,
  input  logic signed [17:0] rpm_left_i,
  input  logic signed [17:0] rpm_right_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               motor_select_o,
  output logic [2:0]         command_kind_o,
  output logic signed [17:0] command_value_o,
  output logic signed [15:0] throttle_left_out_o,
  output logic signed [15:0] throttle_right_out_o,
  output logic               notify_o,
  output logic               last_o
);

  logic [16:0]      max_rpm_q, rev_cur_q;
  logic [14:0]      start_q, turn_q, accel_q;
  logic             rev_en_q;
  dd_pkg::dd_cfg_t  cfg;
  dd_pkg::dd_item_t f_item, q_item;
  logic             push, q_full, q_empty, pop;

  function automatic logic [14:0] cap_q(input logic [14:0] r);
    return (r > 15'd16384) ? 15'd16384 : r;
  endfunction

  // Register file; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rpm_q <= 17'd10000;
      start_q   <= 15'd4096;
      turn_q    <= 15'd4096;
      accel_q   <= 15'd164;
      rev_en_q  <= 1'b0;
      rev_cur_q <= 17'd10000;
    end else if (cfg_we_i) begin
      case (dd_pkg::dd_reg_e'(cfg_index_i))
        dd_pkg::REG_MAX_RPM:     max_rpm_q <= cfg_data_i;
        dd_pkg::REG_START_SPEED: start_q   <= cfg_data_i[14:0];
        dd_pkg::REG_TURN_RATE:   turn_q    <= cfg_data_i[14:0];
        dd_pkg::REG_ACCEL_STEP:  accel_q   <= cfg_data_i[14:0];
        dd_pkg::REG_REV_EN:      rev_en_q  <= cfg_data_i[0];
        dd_pkg::REG_REV_CUR:     rev_cur_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Treat a zero max_rpm as one; clamp speed settings to 1.0.
  assign cfg.max_rpm     = (max_rpm_q == '0) ? 17'd1 : max_rpm_q;
  assign cfg.start_speed = cap_q(start_q);
  assign cfg.turn_rate   = cap_q(turn_q);
  assign cfg.accel_step  = cap_q(accel_q);
  assign cfg.rev_en      = rev_en_q;
  assign cfg.rev_cur     = rev_cur_q;

  dd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .rpm_left_i  (rpm_left_i),
    .rpm_right_i (rpm_right_i),
    .max_rpm_i   (cfg.max_rpm),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (f_item)
  );

  dd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  dd_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg),
    .empty_i              (q_empty),
    .item_i               (q_item),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .motor_select_o       (motor_select_o),
    .command_kind_o       (command_kind_o),
    .command_value_o      (command_value_o),
    .throttle_left_out_o  (throttle_left_out_o),
    .throttle_right_out_o (throttle_right_out_o),
    .notify_o             (notify_o),
    .last_o               (last_o)
  );

endmodule

// File: hdl/dd_front.sv
module dd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         operation_i,
  input  logic signed [17:0] rpm_left_i,
  input  logic signed [17:0] rpm_right_i,
  input  logic [16:0]        max_rpm_i,
  input  logic               q_full_i,
  output logic               push_o,
  output dd_pkg::dd_item_t   item_o
);

  logic               s_valid_q, s_valid_d;
  dd_pkg::dd_item_t   s_item_q;
  logic signed [18:0] sum, sum_adj;
  logic signed [17:0] avg;
  logic [17:0]        mag;
  logic [20:0]        m10;
  logic [24:0]        m100;
  logic               accept, op_ok;

  assign in_stall_o = s_valid_q & q_full_i;
  assign push_o     = s_valid_q & ~q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign op_ok      = operation_i <= 4'(dd_pkg::OP_ACC_OFF);
  assign item_o     = s_item_q;

  // mean rpm, truncated toward zero
  assign sum     = 19'(rpm_left_i) + 19'(rpm_right_i);
  assign sum_adj = sum + (sum[18] ? 19'sd1 : 19'sd0);
  assign avg     = sum_adj[18:1];
  assign mag     = avg[17] ? 18'(-avg) : 18'(avg);
  assign m10     = (21'(mag) << 3) + (21'(mag) << 1);
  assign m100    = (25'(m10) << 3) + (25'(m10) << 1);

  always_comb begin
    s_valid_d = s_valid_q;
    if (accept) begin
      s_valid_d = op_ok;
    end else if (push_o) begin
      s_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_item_q.op     <= dd_pkg::dd_op_e'(operation_i);
      s_item_q.neg    <= avg[17];
      s_item_q.nz     <= avg != 18'sd0;
      s_item_q.mag    <= mag;
      s_item_q.fast   <= m10 > 21'(max_rpm_i);
      s_item_q.rev_ok <= m100 >= 25'(max_rpm_i);
    end
  end

endmodule

// File: hdl/dd_queue.sv
module dd_queue #(
  parameter int Depth = dd_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dd_pkg::dd_item_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output dd_pkg::dd_item_t item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  dd_pkg::dd_item_t    mem_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign item_o  = mem_q[rd_q];

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop_i) rd_q <= nxt(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// File: hdl/dd_back.sv
module dd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dd_pkg::dd_cfg_t    cfg_i,
  input  logic               empty_i,
  input  dd_pkg::dd_item_t   item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               motor_select_o,
  output logic [2:0]         command_kind_o,
  output logic signed [17:0] command_value_o,
  output logic signed [15:0] throttle_left_out_o,
  output logic signed [15:0] throttle_right_out_o,
  output logic               notify_o,
  output logic               last_o
);

  localparam int GKill  = 0;
  localparam int GBrk   = 1;
  localparam int GZero  = 2;
  localparam int GDrive = 3;
  localparam logic signed [15:0] QOne = 16'sd16384;

  dd_pkg::dd_state_e  state_q, state_d;
  dd_pkg::dd_item_t   item_q, item_d;
  logic [14:0]        quo_q, quo_d;
  logic [17:0]        rem_q, rem_d, rem2;
  logic [3:0]         cnt_q, cnt_d;

  logic signed [15:0] speed_q, speed_d, turn_q, turn_d, sd_q, sd_d, td_q, td_d;
  logic signed [16:0] tl_q, tl_d, tr_q, tr_d;
  logic               moving_q, moving_d, accel_q, accel_d, braking_q, braking_d;

  logic [3:0]         mask_q, mask_d;
  logic               motor_q, motor_d, note_q, note_d, sel_q, sel_d;
  dd_pkg::dd_kind_e   bkind_q, bkind_d;
  logic signed [17:0] bval_q, bval_d, rpm_l_q, rpm_l_d, rpm_r_q, rpm_r_d;

  logic               ov_q, ov_d, load;
  logic               o_motor, o_last;
  dd_pkg::dd_kind_e   o_kind;
  logic signed [17:0] o_val;

  // execute-step scratch
  logic signed [15:0] mq;
  logic signed [16:0] vl, vr;
  logic               do_upd, note_in, changed;
  // multiply scratch
  logic signed [16:0] thr;
  logic [14:0]        tmag;
  logic [31:0]        prod;
  logic signed [17:0] rpm;
  logic [3:0]         mask_nx;

  function automatic logic signed [15:0] clip1(input logic signed [16:0] v);
    if (v < -17'sd16384) return -16'sd16384;
    if (v > 17'sd16384) return 16'sd16384;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] sgn_mul(input logic [14:0] a,
                                                 input logic signed [15:0] s);
    if (s == 16'sd0) return 16'sd0;
    if (s < 16'sd0) return -$signed({1'b0, a});
    return $signed({1'b0, a});
  endfunction

  assign rem2 = {rem_q[16:0], 1'b0};
  assign mq   = item_q.neg ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign thr  = sel_q ? tr_q : tl_q;
  assign tmag = (thr < -17'sd16384 || thr > 17'sd16384) ? 15'd16384 :
                (thr < 17'sd0 ? 15'(-thr) : thr[14:0]);
  assign prod = 32'(tmag) * 32'(cfg_i.max_rpm);
  assign rpm  = thr < 17'sd0 ? -$signed(prod[31:14]) : $signed(prod[31:14]);
  assign load = ov_q ? ~out_stall_i : 1'b1;

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    speed_d   = speed_q;
    turn_d    = turn_q;
    sd_d      = sd_q;
    td_d      = td_q;
    tl_d      = tl_q;
    tr_d      = tr_q;
    moving_d  = moving_q;
    accel_d   = accel_q;
    braking_d = braking_q;
    mask_d    = mask_q;
    motor_d   = motor_q;
    note_d    = note_q;
    sel_d     = sel_q;
    bkind_d   = bkind_q;
    bval_d    = bval_q;
    rpm_l_d   = rpm_l_q;
    rpm_r_d   = rpm_r_q;
    ov_d      = ov_q & out_stall_i;
    pop_o     = 1'b0;
    do_upd    = 1'b0;
    note_in   = 1'b0;
    changed   = 1'b0;
    vl        = '0;
    vr        = '0;
    mask_nx   = '0;
    o_motor   = motor_q;
    o_kind    = dd_pkg::KIND_NONE;
    o_val     = '0;
    o_last    = 1'b0;

    case (state_q)
      dd_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          item_d = item_i;
          if (item_i.fast && item_i.mag < 18'(cfg_i.max_rpm)) begin
            rem_d   = item_i.mag;
            quo_d   = '0;
            cnt_d   = '0;
            state_d = dd_pkg::ST_DIV;
          end else begin
            quo_d   = 15'd16384;
            state_d = dd_pkg::ST_EXEC;
          end
        end
      end

      dd_pkg::ST_DIV: begin
        if (rem2 >= 18'(cfg_i.max_rpm)) begin
          rem_d = rem2 - 18'(cfg_i.max_rpm);
          quo_d = {quo_q[13:0], 1'b1};
        end else begin
          rem_d = rem2;
          quo_d = {quo_q[13:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'(dd_pkg::DIV_STEPS - 1)) state_d = dd_pkg::ST_EXEC;
      end

      dd_pkg::ST_EXEC: begin
        mask_nx = '0;
        case (item_q.op)
          dd_pkg::OP_TICK: begin
            if (moving_q) begin
              speed_d = clip1(17'(speed_q) + 17'(sd_q));
              turn_d  = clip1(17'(turn_q) + 17'(td_q));
            end
            do_upd = 1'b1;
          end
          dd_pkg::OP_FWD, dd_pkg::OP_BACK: begin
            if (!braking_q) begin
              if (item_q.fast) begin
                if ((item_q.op == dd_pkg::OP_BACK) ? (!item_q.neg && item_q.nz)
                                                   : item_q.neg) begin
                  speed_d  = mq;
                  moving_d = 1'b1;
                end else begin
                  braking_d = 1'b1;
                  moving_d  = 1'b0;
                end
              end else begin
                speed_d  = (item_q.op == dd_pkg::OP_BACK) ?
                           $signed({1'b0, cfg_i.start_speed}) :
                           -$signed({1'b0, cfg_i.start_speed});
                moving_d = 1'b1;
              end
              do_upd  = 1'b1;
              note_in = 1'b1;
            end
          end
          dd_pkg::OP_LEFT, dd_pkg::OP_RIGHT: begin
            if (!braking_q) begin
              if (item_q.fast) speed_d = mq;
              turn_d   = (item_q.op == dd_pkg::OP_LEFT) ?
                         $signed({1'b0, cfg_i.turn_rate}) :
                         -$signed({1'b0, cfg_i.turn_rate});
              moving_d = 1'b1;
              do_upd   = 1'b1;
              note_in  = 1'b1;
            end
          end
          dd_pkg::OP_IDLE, dd_pkg::OP_BRK_OFF: begin
            mask_nx[GKill] = 1'b1;
            moving_d  = 1'b0;
            speed_d   = '0;
            turn_d    = '0;
            sd_d      = '0;
            td_d      = '0;
            accel_d   = 1'b0;
            braking_d = 1'b0;
            do_upd    = 1'b1;
            note_in   = 1'b1;
          end
          dd_pkg::OP_BRK_ON: begin
            braking_d = 1'b1;
            moving_d  = 1'b0;
            do_upd    = 1'b1;
            note_in   = 1'b1;
          end
          dd_pkg::OP_ACC_ON, dd_pkg::OP_ACC_OFF: begin
            accel_d = item_q.op == dd_pkg::OP_ACC_ON;
            do_upd  = 1'b1;
            note_in = 1'b1;
          end
          default: begin
          end
        endcase

        note_d = 1'b0;
        if (do_upd) begin
          if (braking_d) begin
            mask_nx[GBrk] = 1'b1;
            if (cfg_i.rev_en && item_q.rev_ok) begin
              bkind_d = dd_pkg::KIND_CURRENT;
              bval_d  = item_q.neg ? $signed({1'b0, cfg_i.rev_cur}) :
                                     -$signed({1'b0, cfg_i.rev_cur});
            end else begin
              bkind_d = dd_pkg::KIND_BRAKE;
              bval_d  = '0;
            end
          end else begin
            sd_d = accel_d ? sgn_mul(cfg_i.accel_step, speed_d) : 16'sd0;
            td_d = accel_d ? sgn_mul(cfg_i.accel_step, turn_d) : 16'sd0;
            vl   = 17'(speed_d) + ((turn_d < 16'sd0) ? 17'(turn_d) : 17'sd0);
            vr   = 17'(speed_d) - ((turn_d > 16'sd0) ? 17'(turn_d) : 17'sd0);
            changed = (vl != tl_q) || (vr != tr_q);
            mask_nx[GZero] = speed_d == 16'sd0;
            if (changed || moving_d) begin
              mask_nx[GDrive] = 1'b1;
              tl_d = vl;
              tr_d = vr;
            end
            note_d = changed || note_in;
          end
        end
        mask_d  = mask_nx;
        motor_d = 1'b0;
        sel_d   = 1'b0;
        if (mask_nx[GDrive]) begin
          state_d = dd_pkg::ST_MUL;
        end else if (mask_nx != '0) begin
          state_d = dd_pkg::ST_EMIT;
        end else begin
          state_d = dd_pkg::ST_IDLE;
        end
      end

      dd_pkg::ST_MUL: begin
        if (sel_q) begin
          rpm_r_d = rpm;
          state_d = dd_pkg::ST_EMIT;
        end else begin
          rpm_l_d = rpm;
        end
        sel_d = ~sel_q;
      end

      dd_pkg::ST_EMIT: begin
        mask_nx = mask_q;
        if (mask_q[GKill]) begin
          o_kind = dd_pkg::KIND_KILL;
          if (motor_q) mask_nx[GKill] = 1'b0;
        end else if (mask_q[GBrk]) begin
          o_kind = bkind_q;
          o_val  = bval_q;
          if (motor_q) mask_nx[GBrk] = 1'b0;
        end else if (mask_q[GZero]) begin
          o_kind = dd_pkg::KIND_CURRENT;
          if (motor_q) mask_nx[GZero] = 1'b0;
        end else begin
          if ((motor_q ? tr_q : tl_q) == 17'sd0) begin
            o_kind = dd_pkg::KIND_CURRENT;
          end else begin
            o_kind = dd_pkg::KIND_RPM;
            o_val  = motor_q ? rpm_r_q : rpm_l_q;
          end
          if (motor_q) mask_nx[GDrive] = 1'b0;
        end
        o_last = motor_q && mask_nx == '0;
        if (load) begin
          ov_d    = 1'b1;
          mask_d  = mask_nx;
          motor_d = ~motor_q;
          if (o_last) state_d = dd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = dd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dd_pkg::ST_IDLE;
      speed_q   <= '0;
      turn_q    <= '0;
      sd_q      <= '0;
      td_q      <= '0;
      tl_q      <= '0;
      tr_q      <= '0;
      moving_q  <= 1'b0;
      accel_q   <= 1'b0;
      braking_q <= 1'b0;
      mask_q    <= '0;
      motor_q   <= 1'b0;
      sel_q     <= 1'b0;
      cnt_q     <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      speed_q   <= speed_d;
      turn_q    <= turn_d;
      sd_q      <= sd_d;
      td_q      <= td_d;
      tl_q      <= tl_d;
      tr_q      <= tr_d;
      moving_q  <= moving_d;
      accel_q   <= accel_d;
      braking_q <= braking_d;
      mask_q    <= mask_d;
      motor_q   <= motor_d;
      sel_q     <= sel_d;
      cnt_q     <= cnt_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    note_q  <= note_d;
    bkind_q <= bkind_d;
    bval_q  <= bval_d;
    rpm_l_q <= rpm_l_d;
    rpm_r_q <= rpm_r_d;
    if (state_q == dd_pkg::ST_EMIT && load) begin
      motor_select_o       <= o_motor;
      command_kind_o       <= o_kind;
      command_value_o      <= o_val;
      throttle_left_out_o  <= tl_q[15:0];
      throttle_right_out_o <= tr_q[15:0];
      notify_o             <= note_q;
      last_o               <= o_last;
    end
  end

  assign out_valid_o = ov_q;

`ifndef SYNTHESIS
  a_emit_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dd_pkg::ST_EMIT |-> mask_q != '0)
    else $error("emit state with nothing pending");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == dd_pkg::ST_IDLE && !empty_i)
    else $error("queue popped outside idle");
  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    speed_q <= QOne && speed_q >= -QOne && turn_q <= QOne && turn_q >= -QOne)
    else $error("speed or turn beyond one");
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dd_pkg::ST_DIV |-> cnt_q < 4'(dd_pkg::DIV_STEPS))
    else $error("divider ran past its steps");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q && $stable(command_value_o) && $stable(last_o))
    else $error("stalled result changed");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

typedef struct packed {
  logic        motor;
  logic [2:0]  kind;
  logic [17:0] value;
  logic [15:0] thr_l;
  logic [15:0] thr_r;
  logic        notify;
  logic        last;
} dd_cmd_t;

// Scoreboard for the motor command stream: queue the commands predicted for
// each accepted request and match them, oldest first, against the outputs.
class dd_cmd_scoreboard;
  dd_cmd_t pending_cmds[$];
  int      errors;

  function void note_cmds(dd_cmd_t cmds[$]);
    foreach (cmds[i]) pending_cmds.push_back(cmds[i]);
  endfunction

  task report(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  task check_cmd(dd_cmd_t got);
    dd_cmd_t want;
    if (pending_cmds.size() == 0) begin
      report($sformatf("unexpected command kind=%0d value=%0d", got.kind,
                       $signed(got.value)));
      return;
    end
    want = pending_cmds.pop_front();
    if (got !== want) begin
      report($sformatf({"got m=%0d k=%0d v=%0d tl=%0d tr=%0d n=%0d l=%0d",
                        " want m=%0d k=%0d v=%0d tl=%0d tr=%0d n=%0d l=%0d"},
                       got.motor, got.kind, $signed(got.value), $signed(got.thr_l),
                       $signed(got.thr_r), got.notify, got.last,
                       want.motor, want.kind, $signed(want.value), $signed(want.thr_l),
                       $signed(want.thr_r), want.notify, want.last));
    end
  endtask
endclass

module tb_top;

  localparam longint Q1 = 16384;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_index_i = '0;
  logic [16:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [3:0]         operation_i = '0;
  logic signed [17:0] rpm_left_i = '0;
  logic signed [17:0] rpm_right_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               motor_select_o;
  logic [2:0]         command_kind_o;
  logic signed [17:0] command_value_o;
  logic signed [15:0] throttle_left_out_o;
  logic signed [15:0] throttle_right_out_o;
  logic               notify_o;
  logic               last_o;

  differential_drive_motion_control dut (.*);

  dd_cmd_scoreboard board = new();
  bit stimulus_done = 1'b0;

  // Predictor copy of the configuration registers.
  longint cfg_max_rpm, cfg_start, cfg_turn_rate, cfg_accel, cfg_rev_en, cfg_rev_cur;
  // Predictor copy of the motion state.
  longint spd, trn, spd_delta, trn_delta, thr_left, thr_right;
  bit     moving, accelerating, braking;
  dd_cmd_t cmd_list[$];

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop well above the slowest legal run.
  initial begin
    #50ms;
    $display("** differential_drive_motion_control: FAILED **");
    $finish;
  end

  function automatic longint clip_q(longint v);
    if (v < -Q1) return -Q1;
    if (v > Q1) return Q1;
    return v;
  endfunction

  function automatic longint sign_of(longint v);
    return v < 0 ? -1 : (v > 0 ? 1 : 0);
  endfunction

  function automatic longint abs_of(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint rpm_limit();
    return cfg_max_rpm == 0 ? 1 : cfg_max_rpm;
  endfunction

  function automatic longint sat_q(longint r);
    return r > Q1 ? Q1 : r;
  endfunction

  // SystemVerilog integer division truncates toward zero, matching the block.
  function automatic longint rpm_to_q(longint avg);
    return clip_q(avg * Q1 / rpm_limit());
  endfunction

  function automatic void add_cmd(logic motor, dd_pkg::dd_kind_e kind, longint value);
    dd_cmd_t c;
    if (cmd_list.size() >= 6) return;
    c = '0;
    c.motor = motor;
    c.kind  = kind;
    c.value = value[17:0];
    cmd_list.push_back(c);
  endfunction

  function automatic void drive_motor(logic motor, longint v);
    if (motor == 1'b0) thr_left = v;
    else thr_right = v;
    if (v == 0) add_cmd(motor, dd_pkg::KIND_CURRENT, 0);
    else add_cmd(motor, dd_pkg::KIND_RPM, clip_q(v) * rpm_limit() / Q1);
  endfunction

  // Mix speed and turn into throttles, or brake, and emit the resulting commands.
  function automatic bit refresh_motors(longint avg, bit force_note);
    longint vl, vr, c;
    bit changed;
    if (braking) begin
      if (cfg_rev_en != 0 && abs_of(avg) * 100 >= rpm_limit()) begin
        c = -sign_of(avg) * cfg_rev_cur;
        add_cmd(1'b0, dd_pkg::KIND_CURRENT, c);
        add_cmd(1'b1, dd_pkg::KIND_CURRENT, c);
      end else begin
        add_cmd(1'b0, dd_pkg::KIND_BRAKE, 0);
        add_cmd(1'b1, dd_pkg::KIND_BRAKE, 0);
      end
      return 1'b0;
    end
    if (accelerating) begin
      spd_delta = sat_q(cfg_accel) * sign_of(spd);
      trn_delta = sat_q(cfg_accel) * sign_of(trn);
    end else begin
      spd_delta = 0;
      trn_delta = 0;
    end
    vl = spd;
    vr = spd;
    if (trn > 0) vr -= trn;
    else if (trn < 0) vl += trn;
    changed = (vl != thr_left) || (vr != thr_right);
    if (spd == 0) begin
      add_cmd(1'b0, dd_pkg::KIND_CURRENT, 0);
      add_cmd(1'b1, dd_pkg::KIND_CURRENT, 0);
    end
    if (changed || moving) begin
      drive_motor(1'b0, vl);
      drive_motor(1'b1, vr);
    end
    return changed || force_note;
  endfunction

  // Advance the motion state for one request and queue its commands.
  function automatic void predict_motion(logic [3:0] op, logic signed [17:0] rl,
                                         logic signed [17:0] rr);
    longint avg, dir;
    bit fast, note;
    avg = (longint'(rl) + longint'(rr)) / 2;
    fast = abs_of(avg) * 10 > rpm_limit();
    note = 1'b0;
    cmd_list.delete();
    case (op)
      dd_pkg::OP_TICK: begin
        if (moving) begin
          spd = clip_q(spd + spd_delta);
          trn = clip_q(trn + trn_delta);
        end
        note = refresh_motors(avg, 1'b0);
      end
      dd_pkg::OP_FWD, dd_pkg::OP_BACK: begin
        dir = (op == dd_pkg::OP_BACK) ? 1 : -1;
        if (!braking) begin
          if (fast) begin
            if (dir == sign_of(avg)) begin
              spd = rpm_to_q(avg);
              moving = 1'b1;
            end else begin
              braking = 1'b1;
              moving = 1'b0;
            end
          end else begin
            spd = sat_q(cfg_start) * dir;
            moving = 1'b1;
          end
          note = refresh_motors(avg, 1'b1);
        end
      end
      dd_pkg::OP_LEFT, dd_pkg::OP_RIGHT: begin
        if (!braking) begin
          if (fast) spd = rpm_to_q(avg);
          trn = (op == dd_pkg::OP_LEFT) ? sat_q(cfg_turn_rate) : -sat_q(cfg_turn_rate);
          moving = 1'b1;
          note = refresh_motors(avg, 1'b1);
        end
      end
      dd_pkg::OP_IDLE, dd_pkg::OP_BRK_OFF: begin
        moving = 1'b0;
        add_cmd(1'b0, dd_pkg::KIND_KILL, 0);
        add_cmd(1'b1, dd_pkg::KIND_KILL, 0);
        spd = 0; spd_delta = 0; trn = 0; trn_delta = 0;
        accelerating = 1'b0;
        braking = 1'b0;
        note = refresh_motors(avg, 1'b1);
      end
      dd_pkg::OP_BRK_ON: begin
        braking = 1'b1;
        moving = 1'b0;
        note = refresh_motors(avg, 1'b1);
      end
      dd_pkg::OP_ACC_ON, dd_pkg::OP_ACC_OFF: begin
        accelerating = (op == dd_pkg::OP_ACC_ON);
        note = refresh_motors(avg, 1'b1);
      end
      default: ;
    endcase
    foreach (cmd_list[i]) begin
      cmd_list[i].thr_l  = thr_left[15:0];
      cmd_list[i].thr_r  = thr_right[15:0];
      cmd_list[i].notify = note;
      cmd_list[i].last   = (i == cmd_list.size() - 1);
    end
    board.note_cmds(cmd_list);
  endfunction

  task automatic write_reg(dd_pkg::dd_reg_e idx, longint value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[16:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      dd_pkg::REG_MAX_RPM:     cfg_max_rpm = value & 17'h1FFFF;
      dd_pkg::REG_START_SPEED: cfg_start = value & 15'h7FFF;
      dd_pkg::REG_TURN_RATE:   cfg_turn_rate = value & 15'h7FFF;
      dd_pkg::REG_ACCEL_STEP:  cfg_accel = value & 15'h7FFF;
      dd_pkg::REG_REV_EN:      cfg_rev_en = value & 1;
      dd_pkg::REG_REV_CUR:     cfg_rev_cur = value & 17'h1FFFF;
      default: ;
    endcase
  endtask

  // Send one request; draw a gap first, sometimes none. Valid stays up after
  // acceptance until the next gap or settle drops it.
  task automatic send_request(logic [3:0] op, logic signed [17:0] rl,
                              logic signed [17:0] rr, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    rpm_left_i  <= rl;
    rpm_right_i <= rr;
    do @(posedge clk_i); while (in_stall_o);
    predict_motion(op, rl, rr);
  endtask

  // Wait for the block to drain before touching registers.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending_cmds.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Pick rpm values that fall around the 0.1 and 0.01 thresholds or anywhere.
  function automatic logic signed [17:0] pick_rpm();
    longint lim;
    lim = rpm_limit();
    case ($urandom_range(0, 3))
      0: return 18'(longint'($urandom_range(0, 2 * lim / 10 + 2)) - (lim / 10 + 1));
      1: return 18'(longint'($urandom_range(0, 2 * lim + 2)) - lim);
      2: return 18'(longint'($urandom_range(0, lim / 50 + 2)) - (lim / 100 + 1));
      default: return 18'($urandom);
    endcase
  endfunction

  // Output side: stall at random, check each accepted command.
  initial begin
    dd_cmd_t got;
    int hold;
    hold = 0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.motor  = motor_select_o;
        got.kind   = command_kind_o;
        got.value  = command_value_o;
        got.thr_l  = throttle_left_out_o;
        got.thr_r  = throttle_right_out_o;
        got.notify = notify_o;
        got.last   = last_o;
        board.check_cmd(got);
      end
      // Hold stall for a drawn count of cycles; long stretches stay clear.
      if (hold > 0) hold--;
      else begin
        hold = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
        out_stall_i <= (hold > 0);
      end
    end
  end

  initial begin
    logic [3:0] op;
    logic signed [17:0] rl, rr;
    dd_pkg::dd_op_e all_ops[10] = '{dd_pkg::OP_TICK, dd_pkg::OP_FWD, dd_pkg::OP_BACK,
                                    dd_pkg::OP_LEFT, dd_pkg::OP_RIGHT, dd_pkg::OP_IDLE,
                                    dd_pkg::OP_BRK_ON, dd_pkg::OP_BRK_OFF,
                                    dd_pkg::OP_ACC_ON, dd_pkg::OP_ACC_OFF};
    cfg_max_rpm = 10000; cfg_start = 4096; cfg_turn_rate = 4096;
    cfg_accel = 164; cfg_rev_en = 0; cfg_rev_cur = 10000;
    spd = 0; trn = 0; spd_delta = 0; trn_delta = 0; thr_left = 0; thr_right = 0;
    moving = 0; accelerating = 0; braking = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every operation, reserved codes, rpm extremes, braking paths.
    foreach (all_ops[i]) send_request(all_ops[i], 18'sd0, 18'sd0, 1'b1);
    send_request(4'd10, 18'sd0, 18'sd0, 1'b1);
    send_request(4'd15, -18'sd131072, 18'sd131071, 1'b1);
    send_request(dd_pkg::OP_FWD, -18'sd131072, -18'sd131072, 1'b0);  // forward, fast
    send_request(dd_pkg::OP_BACK, 18'sd131071, 18'sd131071, 1'b0);   // back, fast, rpm agrees
    send_request(dd_pkg::OP_FWD, 18'sd0, 18'sd0, 1'b0);              // forward, slow: start speed
    send_request(dd_pkg::OP_LEFT, 18'sd0, 18'sd0, 1'b0);
    send_request(dd_pkg::OP_IDLE, 18'sd0, 18'sd0, 1'b0);
    send_request(dd_pkg::OP_RIGHT, 18'sd50000, 18'sd50000, 1'b0);    // adopt clipped speed
    send_request(dd_pkg::OP_ACC_ON, 18'sd0, 18'sd0, 1'b0);
    send_request(dd_pkg::OP_TICK, 18'sd0, 18'sd0, 1'b0);
    settle();

    // Several register settings, extremes included; random requests under each.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          write_reg(dd_pkg::REG_REV_EN, 1); write_reg(dd_pkg::REG_REV_CUR, 100000);
        end
        1: begin
          write_reg(dd_pkg::REG_MAX_RPM, 1); write_reg(dd_pkg::REG_START_SPEED, 16384);
          write_reg(dd_pkg::REG_TURN_RATE, 16384);
          write_reg(dd_pkg::REG_ACCEL_STEP, 16384);
        end
        2: begin
          write_reg(dd_pkg::REG_MAX_RPM, 100000); write_reg(dd_pkg::REG_START_SPEED, 0);
          write_reg(dd_pkg::REG_TURN_RATE, 0); write_reg(dd_pkg::REG_ACCEL_STEP, 0);
          write_reg(dd_pkg::REG_REV_CUR, 0);
        end
        3: begin
          write_reg(dd_pkg::REG_MAX_RPM, 131071);
          write_reg(dd_pkg::REG_START_SPEED, 32767);
          write_reg(dd_pkg::REG_TURN_RATE, 32767);
          write_reg(dd_pkg::REG_ACCEL_STEP, 32767);
          write_reg(dd_pkg::REG_REV_CUR, 131071); write_reg(dd_pkg::REG_REV_EN, 0);
        end
        4: write_reg(dd_pkg::REG_MAX_RPM, 0);
        default: begin
          write_reg(dd_pkg::REG_MAX_RPM, $urandom_range(1, 100000));
          write_reg(dd_pkg::REG_START_SPEED, $urandom_range(0, 16384));
          write_reg(dd_pkg::REG_TURN_RATE, $urandom_range(0, 16384));
          write_reg(dd_pkg::REG_ACCEL_STEP, $urandom_range(0, 3000));
          write_reg(dd_pkg::REG_REV_EN, $urandom_range(0, 1));
          write_reg(dd_pkg::REG_REV_CUR, $urandom_range(0, 100000));
        end
      endcase
      for (int n = 0; n < 50; n++) begin
        // Favor ticks so acceleration ramps to the clip; rarely send reserved codes.
        case ($urandom_range(0, 9))
          0, 1, 2, 3: op = dd_pkg::OP_TICK;
          4: op = 4'($urandom_range(10, 15));
          default: op = 4'($urandom_range(1, 9));
        endcase
        rl = pick_rpm();
        rr = ($urandom_range(0, 1) == 0) ? rl : pick_rpm();
        send_request(op, rl, rr, $urandom_range(0, 4) != 0);
      end
      settle();
    end

    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    repeat (100) @(posedge clk_i);
    if (board.errors == 0 && board.pending_cmds.size() == 0) begin
      $display("** differential_drive_motion_control: PASSED **");
    end else begin
      $display("** differential_drive_motion_control: FAILED **");
    end
    $finish;
  end
endmodule
